### rtl/fema_pkg.sv
// ----------------------------------------------------------------------------
// fema_pkg
// Shared types, constants and stream field positions for the stiffness
// matrix assembly engine.
// ----------------------------------------------------------------------------
package fema_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_NODES  = 32;
  localparam int DEF_VALUE_BITS = 48;

  // Fixed field widths
  localparam int NODE_W     = 6;   // node number and node count
  localparam int IO_VALUE_W = 48;  // value width on the ports, Q23.24
  localparam int FRAC_BITS  = 24;

  // Stream widths
  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 1;

  // Input tdata field positions
  localparam int ROW_NODE_LSB = 0;
  localparam int ROW_AXIS_LSB = 6;
  localparam int COL_NODE_LSB = 7;
  localparam int COL_AXIS_LSB = 13;
  localparam int VALUE_LSB    = 14;

  typedef enum logic [1:0] {
    CMD_CLEAR     = 2'd0,
    CMD_ACCUM     = 2'd1,
    CMD_CONSTRAIN = 2'd2,
    CMD_READ      = 2'd3
  } cmd_t;

  // Classified command handed from the front to the back
  typedef struct packed {
    cmd_t cmd;
    logic row_ok;
    logic col_ok;
  } ctrl_t;

endpackage

### rtl/fema_ram.sv
// ----------------------------------------------------------------------------
// fema_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module fema_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/fema_front.sv
// ----------------------------------------------------------------------------
// fema_front
// Hold the node count register, take input transfers, turn node/axis pairs
// into degree-of-freedom indices and check them against the active region.
// ----------------------------------------------------------------------------
module fema_front #(
  parameter int MAX_NODES = 32,
  parameter int DOF_BITS  = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [fema_pkg::NODE_W-1:0]     cfg_wr_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [fema_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [fema_pkg::IN_TUSER_W-1:0] in_tuser,
  input  logic                            q_full,
  output logic                            q_push,
  output fema_pkg::ctrl_t                 q_ctrl,
  output logic [DOF_BITS-1:0]             q_row_dof,
  output logic [DOF_BITS-1:0]             q_col_dof,
  output logic [fema_pkg::IO_VALUE_W-1:0] q_value,
  output logic [DOF_BITS:0]               q_span
);
  import fema_pkg::*;

  localparam int CW = (DOF_BITS > NODE_W) ? DOF_BITS + 1 : NODE_W + 1;
  localparam logic [CW-1:0] MAX_N = CW'(MAX_NODES);

  logic [NODE_W-1:0] node_count_r;
  logic [CW-1:0]     active;
  logic [NODE_W-1:0] row_node;
  logic [NODE_W-1:0] col_node;

  function automatic logic [DOF_BITS-1:0] to_dof(input logic [NODE_W-1:0] node,
                                                 input logic axis);
    logic [NODE_W-1:0] base;
    base = node - NODE_W'(1);
    return {(DOF_BITS-1)'(base), axis};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= '0;
    end else if (cfg_wr_en) begin
      node_count_r <= cfg_wr_data;
    end
  end

  // Clamp the node count to what the store can hold
  assign active = (CW'(node_count_r) > MAX_N) ? MAX_N : CW'(node_count_r);

  assign row_node = in_tdata[ROW_NODE_LSB +: NODE_W];
  assign col_node = in_tdata[COL_NODE_LSB +: NODE_W];

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_ctrl.cmd    = cmd_t'(in_tuser);
    q_ctrl.row_ok = (row_node != '0) && (CW'(row_node) <= active);
    q_ctrl.col_ok = (col_node != '0) && (CW'(col_node) <= active);
  end

  assign q_row_dof = to_dof(row_node, in_tdata[ROW_AXIS_LSB]);
  assign q_col_dof = to_dof(col_node, in_tdata[COL_AXIS_LSB]);
  assign q_value   = in_tdata[VALUE_LSB +: IO_VALUE_W];
  assign q_span    = (DOF_BITS+1)'(active) << 1;

endmodule

### rtl/fema_queue.sv
// ----------------------------------------------------------------------------
// fema_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module fema_queue #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             valid
);

  logic [WIDTH-1:0] store_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == 2'd2);
  assign valid    = (count_r != 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/fema_back.sv
// ----------------------------------------------------------------------------
// fema_back
// Sequence one command at a time against the matrix store: sweep for clear
// and constrain, read-modify-write for accumulate, read for read, then hand
// the result to the output register.
// ----------------------------------------------------------------------------
module fema_back #(
  parameter int DOF_BITS   = 6,
  parameter int VALUE_BITS = 48
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  output logic                             q_pop,
  input  fema_pkg::ctrl_t                  q_ctrl,
  input  logic [DOF_BITS-1:0]              q_row_dof,
  input  logic [DOF_BITS-1:0]              q_col_dof,
  input  logic [fema_pkg::IO_VALUE_W-1:0]  q_value,
  input  logic [DOF_BITS:0]                q_span,
  output logic                             ram_we,
  output logic [2*DOF_BITS-1:0]            ram_waddr,
  output logic [VALUE_BITS-1:0]            ram_wdata,
  output logic                             ram_re,
  output logic [2*DOF_BITS-1:0]            ram_raddr,
  input  logic [VALUE_BITS-1:0]            ram_rdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [fema_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [fema_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import fema_pkg::*;

  localparam int SUM_W = ((VALUE_BITS > IO_VALUE_W) ? VALUE_BITS : IO_VALUE_W) + 1;
  localparam logic signed [SUM_W-1:0] VAL_MAX =
    {{(SUM_W-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] VAL_MIN = ~VAL_MAX;
  localparam logic signed [SUM_W-1:0] RD_MAX =
    {{(SUM_W-IO_VALUE_W+1){1'b0}}, {(IO_VALUE_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] RD_MIN = ~RD_MAX;
  localparam logic [VALUE_BITS-1:0] ONE_VAL = (VALUE_BITS > FRAC_BITS + 1) ?
    VALUE_BITS'(64'd1 << FRAC_BITS) : {1'b0, {(VALUE_BITS-1){1'b1}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_CON,
    S_CON_DIAG,
    S_ACC_WB,
    S_RD_WB,
    S_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  ctrl_t                   ctrl_r, ctrl_nxt;
  logic [DOF_BITS-1:0]     row_r, row_nxt;
  logic [DOF_BITS-1:0]     col_r, col_nxt;
  logic [IO_VALUE_W-1:0]   val_r, val_nxt;
  logic [DOF_BITS:0]       span_r, span_nxt;
  logic [DOF_BITS-1:0]     cnt_a_r, cnt_a_nxt;
  logic [DOF_BITS-1:0]     cnt_b_r, cnt_b_nxt;
  logic                    phase_r, phase_nxt;
  logic [IO_VALUE_W-1:0]   res_val_r, res_val_nxt;
  logic                    res_sat_r, res_sat_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [IO_VALUE_W-1:0]   out_data_r, out_data_nxt;
  logic                    out_sat_r, out_sat_nxt;

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] rd_ext;
  logic signed [SUM_W-1:0] rd_clamped;
  logic [VALUE_BITS-1:0]   sum_clamped;
  logic                    sum_sat;
  logic                    a_last;
  logic                    b_last;
  logic                    slot_free;

  // Saturating accumulate of the stored entry and the incoming value
  always_comb begin
    sum = SUM_W'($signed(ram_rdata)) + SUM_W'($signed(val_r));
    sum_sat = 1'b0;
    sum_clamped = sum[VALUE_BITS-1:0];
    if (sum > VAL_MAX) begin
      sum_sat     = 1'b1;
      sum_clamped = VAL_MAX[VALUE_BITS-1:0];
    end else if (sum < VAL_MIN) begin
      sum_sat     = 1'b1;
      sum_clamped = VAL_MIN[VALUE_BITS-1:0];
    end
  end

  // Narrow a stored value to the port range
  always_comb begin
    rd_ext = SUM_W'($signed(ram_rdata));
    if (rd_ext > RD_MAX) begin
      rd_clamped = RD_MAX;
    end else if (rd_ext < RD_MIN) begin
      rd_clamped = RD_MIN;
    end else begin
      rd_clamped = rd_ext;
    end
  end

  assign a_last    = ({1'b0, cnt_a_r} == span_r - 1'b1);
  assign b_last    = ({1'b0, cnt_b_r} == span_r - 1'b1);
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    ctrl_nxt      = ctrl_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    val_nxt       = val_r;
    span_nxt      = span_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    phase_nxt     = phase_r;
    res_val_nxt   = res_val_r;
    res_sat_nxt   = res_sat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_sat_nxt   = out_sat_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = {row_r, col_r};
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = {q_row_dof, q_col_dof};

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          ctrl_nxt    = q_ctrl;
          row_nxt     = q_row_dof;
          col_nxt     = q_col_dof;
          val_nxt     = q_value;
          span_nxt    = q_span;
          cnt_a_nxt   = '0;
          cnt_b_nxt   = '0;
          phase_nxt   = 1'b0;
          res_val_nxt = '0;
          res_sat_nxt = 1'b0;
          state_nxt   = S_DONE;
          unique case (q_ctrl.cmd)
            CMD_CLEAR: begin
              if (q_span != '0) begin
                state_nxt = S_CLEAR;
              end
            end
            CMD_ACCUM: begin
              if (q_ctrl.row_ok && q_ctrl.col_ok) begin
                ram_re    = 1'b1;
                state_nxt = S_ACC_WB;
              end
            end
            CMD_CONSTRAIN: begin
              if (q_ctrl.row_ok) begin
                state_nxt = S_CON;
              end
            end
            CMD_READ: begin
              if (q_ctrl.row_ok && q_ctrl.col_ok) begin
                ram_re    = 1'b1;
                state_nxt = S_RD_WB;
              end
            end
          endcase
        end
      end
      S_CLEAR: begin
        // Zero the active region row by row
        ram_we    = 1'b1;
        ram_waddr = {cnt_a_r, cnt_b_r};
        if (b_last) begin
          cnt_b_nxt = '0;
          if (a_last) begin
            state_nxt = S_DONE;
          end else begin
            cnt_a_nxt = cnt_a_r + 1'b1;
          end
        end else begin
          cnt_b_nxt = cnt_b_r + 1'b1;
        end
      end
      S_CON: begin
        // Alternate between the row entry and the column entry
        ram_we    = 1'b1;
        ram_waddr = phase_r ? {cnt_a_r, row_r} : {row_r, cnt_a_r};
        phase_nxt = !phase_r;
        if (phase_r) begin
          if (a_last) begin
            state_nxt = S_CON_DIAG;
          end else begin
            cnt_a_nxt = cnt_a_r + 1'b1;
          end
        end
      end
      S_CON_DIAG: begin
        ram_we    = 1'b1;
        ram_waddr = {row_r, row_r};
        ram_wdata = ONE_VAL;
        state_nxt = S_DONE;
      end
      S_ACC_WB: begin
        ram_we      = 1'b1;
        ram_wdata   = sum_clamped;
        res_sat_nxt = sum_sat;
        state_nxt   = S_DONE;
      end
      S_RD_WB: begin
        res_val_nxt = rd_clamped[IO_VALUE_W-1:0];
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_val_r;
          out_sat_nxt   = res_sat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ctrl_r     <= ctrl_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    val_r      <= val_nxt;
    span_r     <= span_nxt;
    cnt_a_r    <= cnt_a_nxt;
    cnt_b_r    <= cnt_b_nxt;
    phase_r    <= phase_nxt;
    res_val_r  <= res_val_nxt;
    res_sat_r  <= res_sat_nxt;
    out_data_r <= out_data_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

endmodule

### rtl/fem_matrix_assembly_engine.sv
// ----------------------------------------------------------------------------
// fem_matrix_assembly_engine
// Direct-stiffness assembly of a 2-dof-per-node global matrix in Q23.24.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_wr_en/cfg_wr_data set the node count N (clamped to MAX_NODES); write
//   it only while no command is outstanding. The active region is 2N by 2N.
//   Input stream: in_tuser carries the command (clear, accumulate,
//   constrain, read), in_tdata the row/column node and axis and the value.
//   Every accepted command yields exactly one output transfer: out_tdata is
//   the entry for a read and zero otherwise, out_tuser flags a clamped
//   accumulation.
//   Commands run one at a time through the back-end sequencer, which owns
//   the single write port and single read port of the matrix store:
//     accumulate, read          read, add or clamp, hand over
//     command with a bad node   straight to hand-over
//     clear                     zeroes the region, one entry per cycle
//     constrain                 row and column entries
//                               alternate on the write port
//   A command with a bad node goes from the queue straight to hand-over;
//   accumulate and read pass through a write-back state first.
//   A two-entry queue keeps the input open while the back end works or the
//   receiver stalls; a stalled result holds in the output register.
//   Reset clears the node count and control state only. The store is
//   undefined until a clear has swept it.
// ----------------------------------------------------------------------------
module fem_matrix_assembly_engine #(
  parameter int MAX_NODES  = fema_pkg::DEF_MAX_NODES,
  parameter int VALUE_BITS = fema_pkg::DEF_VALUE_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [fema_pkg::NODE_W-1:0]      cfg_wr_data,   // node_count
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // row_node[5:0], row_axis[6], col_node[12:7], col_axis[13],
  // entry_value[61:14], zero pad [63:62]
  input  logic [fema_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [fema_pkg::IN_TUSER_W-1:0]  in_tuser,      // command[1:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [fema_pkg::OUT_TDATA_W-1:0] out_tdata,     // read_value[47:0]
  output logic [fema_pkg::OUT_TUSER_W-1:0] out_tuser      // saturated[0]
);
  import fema_pkg::*;

  localparam int DOF_BITS = $clog2(2 * MAX_NODES);
  localparam int QW       = $bits(ctrl_t) + 3 * DOF_BITS + 1 + IO_VALUE_W;

  logic                  f_push;
  ctrl_t                 f_ctrl;
  logic [DOF_BITS-1:0]   f_row;
  logic [DOF_BITS-1:0]   f_col;
  logic [IO_VALUE_W-1:0] f_value;
  logic [DOF_BITS:0]     f_span;

  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  logic [QW-1:0]         q_head;
  ctrl_t                 b_ctrl;
  logic [DOF_BITS-1:0]   b_row;
  logic [DOF_BITS-1:0]   b_col;
  logic [IO_VALUE_W-1:0] b_value;
  logic [DOF_BITS:0]     b_span;

  logic                  ram_we;
  logic [2*DOF_BITS-1:0] ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic                  ram_re;
  logic [2*DOF_BITS-1:0] ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;

  // Front: decode node/axis into dof indices and check them
  fema_front #(
    .MAX_NODES (MAX_NODES),
    .DOF_BITS  (DOF_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .q_full      (q_full),
    .q_push      (f_push),
    .q_ctrl      (f_ctrl),
    .q_row_dof   (f_row),
    .q_col_dof   (f_col),
    .q_value     (f_value),
    .q_span      (f_span)
  );

  // Queue: decouple acceptance from the sweeps of the back end
  fema_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data ({f_ctrl, f_row, f_col, f_value, f_span}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_head),
    .valid     (q_valid)
  );

  assign {b_ctrl, b_row, b_col, b_value, b_span} = q_head;

  // Back: execute commands against the store
  fema_back #(
    .DOF_BITS   (DOF_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_ctrl     (b_ctrl),
    .q_row_dof  (b_row),
    .q_col_dof  (b_col),
    .q_value    (b_value),
    .q_span     (b_span),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Matrix store, addressed by {row dof, column dof}
  fema_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (1 << (2 * DOF_BITS))
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

### rtl/fema_checker.sv
// ----------------------------------------------------------------------------
// fema_checker
// Port-level checks for the assembly engine, bound to the top level.
// ----------------------------------------------------------------------------
module fema_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [fema_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [fema_pkg::OUT_TUSER_W-1:0] out_tuser
);

  logic       in_xfer;
  logic       out_xfer;
  logic [3:0] pending_r;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  // Count commands accepted but not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 4'(in_xfer) - 4'(out_xfer);
    end
  end

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered straight after reset");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> pending_r != 4'd0)
    else $error("result transfer without an outstanding command");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 4'd4)
    else $error("more commands in flight than queue and stages hold");

  a_sat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("saturated flag set on a result carrying data");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind fem_matrix_assembly_engine fema_checker u_fema_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### dv/fema_stiffness_mirror.sv
// ----------------------------------------------------------------------------
// fema_stiffness_mirror
// Watches the ports of the assembly engine and keeps its own copy of the
// global stiffness matrix and node count. Every accepted command produces
// one predicted result, and every result transfer is checked in order
// against the oldest prediction.
// ----------------------------------------------------------------------------
module fema_stiffness_mirror (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [fema_pkg::NODE_W-1:0]      cfg_wr_data,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [fema_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [fema_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [fema_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [fema_pkg::OUT_TUSER_W-1:0] out_tuser,
  output int                               fail_count,
  output int                               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import fema_pkg::*;

  localparam int DIM = 2 * DEF_MAX_NODES;

  localparam logic [IO_VALUE_W-1:0] POS_LIMIT = {1'b0, {(IO_VALUE_W-1){1'b1}}};
  localparam logic [IO_VALUE_W-1:0] NEG_LIMIT = {1'b1, {(IO_VALUE_W-1){1'b0}}};
  localparam logic [IO_VALUE_W-1:0] UNIT      = IO_VALUE_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic [IO_VALUE_W-1:0] value;
    logic                  sat;
  } result_t;

  // Store width equals the port width, so 1.0 always fits and reads never clamp
  logic [IO_VALUE_W-1:0] stiffness [DIM*DIM];
  logic [NODE_W-1:0]     node_count;
  result_t               due_q [$];

  function automatic int live_nodes();
    return (node_count > DEF_MAX_NODES) ? DEF_MAX_NODES : int'(node_count);
  endfunction

  function automatic bit dof_of(input logic [NODE_W-1:0] node, input logic axis,
                                output int dof);
    dof = 2 * (int'(node) - 1) + int'(axis);
    return (node != 0) && (int'(node) <= live_nodes());
  endfunction

  // Apply one command to the mirror and return the result it must produce
  function automatic result_t assemble(input cmd_t cmd, input logic [IN_TDATA_W-1:0] word);
    int                    span, r, c;
    bit                    row_ok, col_ok;
    logic [IO_VALUE_W-1:0] addend, held;
    logic [IO_VALUE_W:0]   sum;
    result_t               res;
    res    = '0;
    span   = 2 * live_nodes();
    row_ok = dof_of(word[ROW_NODE_LSB +: NODE_W], word[ROW_AXIS_LSB], r);
    col_ok = dof_of(word[COL_NODE_LSB +: NODE_W], word[COL_AXIS_LSB], c);
    addend = word[VALUE_LSB +: IO_VALUE_W];
    case (cmd)
      CMD_CLEAR: begin
        for (int i = 0; i < span; i++)
          for (int j = 0; j < span; j++) stiffness[i*DIM+j] = '0;
      end
      CMD_ACCUM: begin
        if (row_ok && col_ok) begin
          held = stiffness[r*DIM+c];
          sum  = {held[IO_VALUE_W-1], held} + {addend[IO_VALUE_W-1], addend};
          if (sum[IO_VALUE_W] != sum[IO_VALUE_W-1]) begin
            res.sat = 1'b1;
            stiffness[r*DIM+c] = sum[IO_VALUE_W] ? NEG_LIMIT : POS_LIMIT;
          end else begin
            stiffness[r*DIM+c] = sum[IO_VALUE_W-1:0];
          end
        end
      end
      CMD_CONSTRAIN: begin
        if (row_ok) begin
          for (int i = 0; i < span; i++) begin
            stiffness[r*DIM+i] = '0;
            stiffness[i*DIM+r] = '0;
          end
          stiffness[r*DIM+r] = UNIT;
        end
      end
      default: begin
        if (row_ok && col_ok) res.value = stiffness[r*DIM+c];
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      node_count = '0;
      due_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result transfer with none due: value %h sat %b",
                     $realtime, out_tdata, out_tuser[0]);
        end else begin
          want = due_q.pop_front();
          if (out_tdata !== want.value || out_tuser[0] !== want.sat) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: result mismatch: expected value %h sat %b, got value %h sat %b",
                       $realtime, want.value, want.sat, out_tdata, out_tuser[0]);
          end
        end
      end
      if (in_tvalid && in_tready)
        due_q.insert(due_q.size(), assemble(cmd_t'(in_tuser), in_tdata));
      if (cfg_wr_en) node_count = cfg_wr_data;
    end
    pending <= due_q.size();
  end

endmodule

### dv/fem_matrix_assembly_engine_test.sv
// ----------------------------------------------------------------------------
// fem_matrix_assembly_engine_test
// Drives commands into the assembly engine under several node counts: a
// directed run over the field extremes, saturation, constraints, invalid
// nodes and the clear scope, then weighted random traffic with random gaps
// on both sides. The mirror module checks every result.
// ----------------------------------------------------------------------------
module fem_matrix_assembly_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fema_pkg::*;

  localparam logic [IO_VALUE_W-1:0] POS_LIMIT = {1'b0, {(IO_VALUE_W-1){1'b1}}};
  localparam logic [IO_VALUE_W-1:0] NEG_LIMIT = {1'b1, {(IO_VALUE_W-1){1'b0}}};
  localparam logic [IO_VALUE_W-1:0] UNIT      = IO_VALUE_W'(1) << FRAC_BITS;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [NODE_W-1:0]      cfg_wr_data = '0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic [IN_TUSER_W-1:0]  in_tuser    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  int                     fail_count;
  int                     pending;

  // Stimulus state: effective node count and the entry last accumulated
  int                     live_nodes  = 0;
  logic [2*NODE_W+1:0]    hot_entry   = '0;
  bit                     tx_steady   = 1'b0;
  bit                     rx_steady   = 1'b0;
  logic                   out_took    = 1'b0;
  int                     rx_hold     = 0;

  fem_matrix_assembly_engine u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  fema_stiffness_mirror u_mirror (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver: after each result transfer, draw a random stall.
  // Now and then switch into a steady stretch where ready stays high.
  always @(posedge clk) out_took <= out_tvalid && out_tready;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_took) begin
        if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
        rx_hold = rx_steady ? 0 : $urandom_range(0, 13);
      end
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        rx_hold--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Present one command after a random gap and hold it until the transfer.
  // Entered and left at a falling edge; valid is only lowered when a gap
  // follows, so back-to-back commands keep it high.
  task automatic send_cmd(input cmd_t cmd, input logic [NODE_W-1:0] row_node,
                          input logic row_axis, input logic [NODE_W-1:0] col_node,
                          input logic col_axis, input logic [IO_VALUE_W-1:0] entry);
    int                    gap;
    logic [IN_TDATA_W-1:0] word;
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    word = '0;
    word[ROW_NODE_LSB +: NODE_W]     = row_node;
    word[ROW_AXIS_LSB]               = row_axis;
    word[COL_NODE_LSB +: NODE_W]     = col_node;
    word[COL_AXIS_LSB]               = col_axis;
    word[VALUE_LSB +: IO_VALUE_W]    = entry;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= word;
    do @(posedge clk); while (in_tready !== 1'b1);
    @(negedge clk);
  endtask

  // Hold off input until every predicted result has arrived; the back end
  // has then finished its last sweep as well
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Change the node count only with the engine idle
  task automatic set_nodes(input logic [NODE_W-1:0] count);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    live_nodes  = (count > DEF_MAX_NODES) ? DEF_MAX_NODES : int'(count);
  endtask

  // Mostly a node in range; one in ten anything the field holds
  function automatic logic [NODE_W-1:0] pick_node();
    if (live_nodes == 0 || $urandom_range(0, 9) == 0) return NODE_W'($urandom);
    return NODE_W'($urandom_range(1, live_nodes));
  endfunction

  // Full-range, small, near-limit and whole-unit values in equal shares
  function automatic logic [IO_VALUE_W-1:0] pick_value();
    logic [IO_VALUE_W-1:0] raw;
    raw = IO_VALUE_W'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0:       return raw;
      1:       return {{(IO_VALUE_W-30){raw[29]}}, raw[29:0]};
      2:       return {raw[IO_VALUE_W-1], {20{~raw[IO_VALUE_W-1]}}, raw[26:0]};
      default: return {{(IO_VALUE_W-FRAC_BITS-6){raw[5]}}, raw[5:0], {FRAC_BITS{1'b0}}};
    endcase
  endfunction

  // One random command. Accumulates and reads revisit the last accumulated
  // entry half the time, so sums build up and saturate. Clears are rare,
  // rarer still when the active region is large.
  task automatic random_cmd();
    cmd_t              cmd;
    logic [NODE_W-1:0] row_node, col_node;
    logic              row_axis, col_axis;
    int                draw, clear_share;
    draw        = $urandom_range(0, 999);
    clear_share = (live_nodes >= 16) ? 8 : 30;
    if (draw < clear_share)  cmd = CMD_CLEAR;
    else if (draw < 600)     cmd = CMD_ACCUM;
    else if (draw < 900)     cmd = CMD_READ;
    else                     cmd = CMD_CONSTRAIN;
    row_node = pick_node();
    row_axis = 1'($urandom);
    col_node = pick_node();
    col_axis = 1'($urandom);
    if ((cmd == CMD_ACCUM || cmd == CMD_READ) && $urandom_range(0, 1) == 1)
      {row_node, row_axis, col_node, col_axis} = hot_entry;
    if (cmd == CMD_ACCUM) hot_entry = {row_node, row_axis, col_node, col_axis};
    send_cmd(cmd, row_node, row_axis, col_node, col_axis, pick_value());
  endtask

  initial begin
    logic [NODE_W-1:0] node_plan [10];
    node_plan = '{1, 2, 5, 0, 32, 3, 63, 8, 16, 4};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Node count is zero after reset: every command touches nothing, so
    // the still-undefined store is never read
    send_cmd(CMD_CLEAR,     6'd1, 1'b0, 6'd1, 1'b0, '0);
    send_cmd(CMD_ACCUM,     6'd1, 1'b0, 6'd1, 1'b0, 48'd5);
    send_cmd(CMD_CONSTRAIN, 6'd1, 1'b1, 6'd0, 1'b0, '0);
    send_cmd(CMD_READ,      6'd1, 1'b0, 6'd1, 1'b0, '0);

    // Beyond the node limit the count clamps to the full store; sweep it
    // all once so every later read finds a defined entry
    set_nodes(6'd63);
    send_cmd(CMD_CLEAR,     6'd0, 1'b0, 6'd0, 1'b0, '0);

    // Saturate upwards at the first entry, downwards at the last
    send_cmd(CMD_ACCUM,     6'd1,  1'b0, 6'd1,  1'b0, POS_LIMIT);
    send_cmd(CMD_ACCUM,     6'd1,  1'b0, 6'd1,  1'b0, UNIT);
    send_cmd(CMD_READ,      6'd1,  1'b0, 6'd1,  1'b0, '0);
    send_cmd(CMD_ACCUM,     6'd32, 1'b1, 6'd32, 1'b1, NEG_LIMIT);
    send_cmd(CMD_ACCUM,     6'd32, 1'b1, 6'd32, 1'b1, '1);
    send_cmd(CMD_READ,      6'd32, 1'b1, 6'd32, 1'b1, '0);

    // Constrain the last dof: its row and column go to zero, diagonal to 1.0
    send_cmd(CMD_ACCUM,     6'd1,  1'b0, 6'd32, 1'b1, 48'd12345);
    send_cmd(CMD_ACCUM,     6'd32, 1'b1, 6'd1,  1'b0, -48'sd777);
    send_cmd(CMD_CONSTRAIN, 6'd32, 1'b1, 6'd0,  1'b0, '0);
    send_cmd(CMD_READ,      6'd32, 1'b1, 6'd32, 1'b1, '0);
    send_cmd(CMD_READ,      6'd1,  1'b0, 6'd32, 1'b1, '0);
    send_cmd(CMD_READ,      6'd32, 1'b1, 6'd1,  1'b0, '0);

    // Node zero and nodes past the count: ignored, reads give zero
    send_cmd(CMD_ACCUM,     6'd0,  1'b0, 6'd1,  1'b0, 48'd9);
    send_cmd(CMD_ACCUM,     6'd1,  1'b0, 6'd63, 1'b1, 48'd9);
    send_cmd(CMD_CONSTRAIN, 6'd0,  1'b1, 6'd0,  1'b0, '0);
    send_cmd(CMD_READ,      6'd63, 1'b1, 6'd1,  1'b0, '0);
    send_cmd(CMD_READ,      6'd1,  1'b1, 6'd0,  1'b0, '0);

    // Clear scope: a clear over two nodes must leave this entry alone
    send_cmd(CMD_ACCUM,     6'd5,  1'b1, 6'd7,  1'b0, 48'h1234_5678_9ABC);
    set_nodes(6'd2);
    send_cmd(CMD_CLEAR,     6'd0,  1'b0, 6'd0,  1'b0, '0);
    send_cmd(CMD_READ,      6'd1,  1'b0, 6'd1,  1'b0, '0);
    send_cmd(CMD_READ,      6'd3,  1'b0, 6'd1,  1'b0, '0);
    set_nodes(6'd32);
    send_cmd(CMD_READ,      6'd5,  1'b1, 6'd7,  1'b0, '0);

    // Random traffic under a sequence of node counts, with an occasional
    // full drain of the engine between commands
    foreach (node_plan[p]) begin
      set_nodes(node_plan[p]);
      repeat ((node_plan[p] == 0) ? 40 : 150) begin
        if ($urandom_range(0, 49) == 0) drain();
        random_cmd();
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("fem_matrix_assembly_engine_test OK");
    end else begin
      $display("fem_matrix_assembly_engine_test NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, full clears included
  initial begin
    #4_000_000;
    $display("fem_matrix_assembly_engine_test NOT OK");
    $finish;
  end

endmodule
